>>> design/sdsf_pkg.sv
`timescale 1ns / 1ps

package sdsf_pkg;

    // Format constants
    localparam int MAX_SCALE = 28;
    localparam int NUM_W     = 96;
    localparam int LZ_W      = 7;
    localparam int LZ_CELLS  = 7;
    localparam int QUOT_W    = 26;
    localparam int REM_W     = NUM_W + 1;
    localparam int SCALE_IDX_W = $clog2(MAX_SCALE + 1);
    localparam logic [8:0] EXP_TOP = 9'd223;   // bias 127 plus NUM_W

    typedef logic [MAX_SCALE:0][NUM_W-1:0] pow_tab_t;
    typedef logic [MAX_SCALE:0][LZ_W-1:0]  len_tab_t;

    // Beat moving through the leading-zero cells
    typedef struct packed {
        logic             valid;
        logic             negative;
        logic             error;
        logic             zero;
        logic [NUM_W-1:0] num;
        logic [LZ_W-1:0]  lz;
        logic [LZ_W-1:0]  db;
        logic [SCALE_IDX_W-1:0] sidx;
    } lz_beat_t;

    // Beat moving through the divider cells
    typedef struct packed {
        logic              valid;
        logic              negative;
        logic              error;
        logic              zero;
        logic [7:0]        expo;
        logic [NUM_W-1:0]  den;
        logic [REM_W-1:0]  rem;
        logic [QUOT_W-1:0] quot;
    } div_beat_t;

    // Powers of ten, left aligned so the top bit is set
    function automatic pow_tab_t pow_tab_make();
        pow_tab_t         tab;
        logic [NUM_W-1:0] p;
        logic [NUM_W-1:0] v;
        p = NUM_W'(1);
        for (int i = 0; i <= MAX_SCALE; i++) begin
            v = p;
            for (int j = 0; j < NUM_W; j++) begin
                if (!v[NUM_W-1]) begin
                    v = {v[NUM_W-2:0], 1'b0};
                end
            end
            tab[i] = v;
            p = p * NUM_W'(10);
        end
        return tab;
    endfunction

    // Bit length of each power of ten
    function automatic len_tab_t len_tab_make();
        len_tab_t         tab;
        logic [NUM_W-1:0] p;
        int               n;
        p = NUM_W'(1);
        for (int i = 0; i <= MAX_SCALE; i++) begin
            n = 0;
            for (int j = 0; j < NUM_W; j++) begin
                if (p[j]) begin
                    n = j + 1;
                end
            end
            tab[i] = LZ_W'(n);
            p = p * NUM_W'(10);
        end
        return tab;
    endfunction

    localparam pow_tab_t POW_TAB = pow_tab_make();
    localparam len_tab_t LEN_TAB = len_tab_make();

endpackage

>>> design/scaled_decimal_to_single_float.sv
`timescale 1ns / 1ps

// Channel  Ports                                                    Dir
// s_       s_valid s_ready s_coefficient_low/high s_scale s_negative in
// m_       m_valid m_ready m_float_bits m_error                     out
//
// The chain has 7 leading-zero cells, 26 divider cells and one round stage.
// One beat is taken every cycle while m_ready does not stall the output; the cell chain sets that rate.
// The whole chain advances together when the output register is empty or taken.
// A stall at m_ready holds every stage and drops s_ready in the same cycle.
// Synchronous reset clears the valid bits only.
module scaled_decimal_to_single_float
    import sdsf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_coefficient_low,
    input  logic [31:0] s_coefficient_high,
    input  logic [7:0]  s_scale,
    input  logic        s_negative,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_float_bits,
    output logic        m_error
);

    logic      adv;
    lz_beat_t  lz_pipe [0:LZ_CELLS];
    div_beat_t div_pipe [0:QUOT_W];
    logic      err_in;
    logic [SCALE_IDX_W-1:0] sidx;
    logic [8:0] expo_wide;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Input beat
    always_comb begin
        err_in = (s_scale > 8'(MAX_SCALE));
        sidx   = err_in ? '0 : s_scale[SCALE_IDX_W-1:0];
        lz_pipe[0].valid    = s_valid;
        lz_pipe[0].negative = s_negative;
        lz_pipe[0].error    = err_in;
        lz_pipe[0].num      = {s_coefficient_high, s_coefficient_low};
        lz_pipe[0].zero     = ({s_coefficient_high, s_coefficient_low} == '0);
        lz_pipe[0].lz       = '0;
        lz_pipe[0].db       = LEN_TAB[sidx];
        lz_pipe[0].sidx     = sidx;
    end

    // Leading-zero normalization chain
    genvar gi;
    generate
        for (gi = 0; gi < LZ_CELLS; gi++) begin : g_lz
            sdsf_lz_cell #(.SHIFT(64 >> gi)) u_lz (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (adv),
                .beat_in (lz_pipe[gi]),
                .beat_out(lz_pipe[gi+1])
            );
        end
    endgenerate

    // Divider setup: exponent for a quotient in [1,2)
    always_comb begin
        expo_wide = EXP_TOP - {2'b00, lz_pipe[LZ_CELLS].lz}
                  - {2'b00, lz_pipe[LZ_CELLS].db};
        div_pipe[0].valid    = lz_pipe[LZ_CELLS].valid;
        div_pipe[0].negative = lz_pipe[LZ_CELLS].negative;
        div_pipe[0].error    = lz_pipe[LZ_CELLS].error;
        div_pipe[0].zero     = lz_pipe[LZ_CELLS].zero;
        div_pipe[0].expo     = expo_wide[7:0];
        div_pipe[0].den      = POW_TAB[lz_pipe[LZ_CELLS].sidx];
        div_pipe[0].rem      = {1'b0, lz_pipe[LZ_CELLS].num};
        div_pipe[0].quot     = '0;
    end

    // Restoring divider chain, one quotient bit per cell
    generate
        for (gi = 0; gi < QUOT_W; gi++) begin : g_div
            sdsf_div_cell u_div (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (adv),
                .beat_in (div_pipe[gi]),
                .beat_out(div_pipe[gi+1])
            );
        end
    endgenerate

    sdsf_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .beat_in   (div_pipe[QUOT_W]),
        .valid     (m_valid),
        .float_bits(m_float_bits),
        .error     (m_error)
    );

    // Checks
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_float_bits == 32'd0)
        else $error("error beat with nonzero result");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready does not follow output stage");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("valid result right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_float_bits))
        else $error("result changed while stalled");

endmodule

>>> design/sdsf_lz_cell.sv
`timescale 1ns / 1ps

module sdsf_lz_cell
    import sdsf_pkg::*;
#(
    parameter int SHIFT = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  lz_beat_t beat_in,
    output lz_beat_t beat_out
);

    lz_beat_t beat_reg;
    lz_beat_t beat_next;

    // Shift out one power-of-two group of leading zeros
    always_comb begin
        beat_next = beat_in;
        if (beat_in.num[NUM_W-1 -: SHIFT] == '0) begin
            beat_next.num = beat_in.num << SHIFT;
            beat_next.lz  = beat_in.lz + LZ_W'(SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg.valid <= 1'b0;
        end else if (en) begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

>>> design/sdsf_div_cell.sv
`timescale 1ns / 1ps

module sdsf_div_cell
    import sdsf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  div_beat_t beat_in,
    output div_beat_t beat_out
);

    div_beat_t         beat_reg;
    div_beat_t         beat_next;
    logic [REM_W:0]    diff;
    logic              ge;

    // One restoring step: trial subtract, keep quotient bit, double remainder
    always_comb begin
        diff = {1'b0, beat_in.rem} - {2'b00, beat_in.den};
        ge   = !diff[REM_W];
        beat_next = beat_in;
        beat_next.quot = {beat_in.quot[QUOT_W-2:0], ge};
        if (ge) begin
            beat_next.rem = {diff[REM_W-2:0], 1'b0};
        end else begin
            beat_next.rem = {beat_in.rem[REM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg.valid <= 1'b0;
        end else if (en) begin
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

>>> design/sdsf_round.sv
`timescale 1ns / 1ps

module sdsf_round
    import sdsf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  div_beat_t   beat_in,
    output logic        valid,
    output logic [31:0] float_bits,
    output logic        error
);

    logic        valid_reg;
    logic [31:0] bits_reg;
    logic [31:0] bits_next;
    logic        error_reg;
    logic [23:0] mant;
    logic        guard;
    logic        sticky;
    logic        up;
    logic [24:0] sum;
    logic [7:0]  expo;
    logic        rem_nz;

    // Pick the 24-bit mantissa, then round to nearest even; error beats give zero, zero beats a signed zero
    always_comb begin
        rem_nz = (beat_in.rem != '0);
        if (beat_in.quot[QUOT_W-1]) begin
            mant   = beat_in.quot[25:2];
            guard  = beat_in.quot[1];
            sticky = beat_in.quot[0] | rem_nz;
            expo   = beat_in.expo;
        end else begin
            mant   = beat_in.quot[24:1];
            guard  = beat_in.quot[0];
            sticky = rem_nz;
            expo   = beat_in.expo - 8'd1;
        end
        up  = guard & (sticky | mant[0]);
        sum = {1'b0, mant} + {24'd0, up};
        if (sum[24]) begin
            expo = expo + 8'd1;
        end
        priority if (beat_in.error) begin
            bits_next = 32'd0;
        end else if (beat_in.zero) begin
            bits_next = {beat_in.negative, 31'd0};
        end else begin
            bits_next = {beat_in.negative, expo, sum[22:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= beat_in.valid;
            bits_reg  <= bits_next;
            error_reg <= beat_in.error;
        end
    end

    assign valid      = valid_reg;
    assign float_bits = bits_reg;
    assign error      = error_reg;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sdsf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_ITEMS   = 1000;

    typedef struct {
        logic [95:0] coef;
        logic [7:0]  scale;
        logic        neg;
    } decimal_t;

    typedef struct {
        logic [31:0] bits;
        logic        err;
    } float_res_t;

    typedef struct {
        decimal_t    item;
        bit          typed;
        float_res_t  res;
    } vector_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_coefficient_low;
    logic [31:0] s_coefficient_high;
    logic [7:0]  s_scale;
    logic        s_negative;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_float_bits;
    logic        m_error;

    float_res_t  pending_floats[$];
    vector_t     vectors[$];
    int          fail_count;
    int          sent_count;
    int          checked_count;
    int          error_beats;
    int          idle_cycles;
    bit          hold_req;

    scaled_decimal_to_single_float dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_coefficient_low  (s_coefficient_low),
        .s_coefficient_high (s_coefficient_high),
        .s_scale            (s_scale),
        .s_negative         (s_negative),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_float_bits       (m_float_bits),
        .m_error            (m_error)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Exact division then a single round to nearest even
    function automatic float_res_t decimal_to_float(decimal_t d);
        float_res_t  r;
        logic [255:0] num;
        logic [255:0] den;
        logic [255:0] quo;
        logic [255:0] rmd;
        logic [31:0]  q;
        logic [31:0]  mant;
        logic [31:0]  low;
        logic [31:0]  half;
        int           nb;
        int           db;
        int           k;
        int           extra;
        int           expo;
        bit           up;
        r.bits = 32'h0;
        r.err  = 1'b0;
        if (d.scale > MAX_SCALE) begin
            r.err = 1'b1;
            return r;
        end
        if (d.coef == 96'h0) begin
            r.bits = {d.neg, 31'h0};
            return r;
        end
        num = 256'(d.coef);
        den = 256'd1;
        for (int i = 0; i < d.scale; i++) begin
            den = den * 10;
        end
        nb = 0;
        db = 0;
        for (int i = 0; i < 256; i++) begin
            if (num[i]) nb = i + 1;
            if (den[i]) db = i + 1;
        end
        k = 26 + db - nb;
        if (k >= 0) begin
            num = num << k;
        end else begin
            den = den << (-k);
        end
        quo = num / den;
        rmd = num % den;
        q = quo[31:0];
        extra = 0;
        while ((q >> extra) >= 32'h0100_0000) extra++;
        mant = q >> extra;
        low  = q & ((32'h1 << extra) - 1);
        half = (extra > 0) ? (32'h1 << (extra - 1)) : 32'h0;
        up = (extra > 0) && (low > half || (low == half && (rmd != 0 || mant[0])));
        expo = 127 + 23 + extra - k;
        if (up) begin
            mant++;
            if (mant == 32'h0100_0000) begin
                mant = mant >> 1;
                expo++;
            end
        end
        r.bits = {d.neg, 8'(expo), mant[22:0]};
        return r;
    endfunction

    // Offer one beat; leave valid high if the burst goes on
    task automatic send_decimal(decimal_t d, bit typed, float_res_t res, bit keep_going);
        s_valid            <= 1'b1;
        s_coefficient_low  <= d.coef[63:0];
        s_coefficient_high <= d.coef[95:64];
        s_scale            <= d.scale;
        s_negative         <= d.neg;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_floats.push_back(typed ? res : decimal_to_float(d));
        sent_count++;
        if (!keep_going) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic add_vector(logic [95:0] c, logic [7:0] sc, logic ng,
                              bit typed, logic [31:0] bits, logic err);
        vector_t v;
        v.item.coef  = c;
        v.item.scale = sc;
        v.item.neg   = ng;
        v.typed      = typed;
        v.res.bits   = bits;
        v.res.err    = err;
        vectors.push_back(v);
    endtask

    function automatic decimal_t random_decimal();
        decimal_t d;
        int       kind;
        kind = $urandom_range(0, 9);
        d.coef = {$urandom, $urandom, $urandom};
        case (kind)
            0: begin
                d.coef = 96'($urandom_range(0, 1000));
            end
            1: begin
                d.coef = d.coef >> $urandom_range(0, 95);
            end
            2: begin
                d.coef = 96'h0;
            end
            3: begin
                d.coef = 96'($urandom_range(0, 3)) << $urandom_range(0, 94);
            end
            default: begin
            end
        endcase
        d.scale = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, MAX_SCALE));
        d.neg   = 1'($urandom_range(0, 1));
        return d;
    endfunction

    // Result checker and stall pattern
    initial begin
        float_res_t want;
        int         mode;
        int         phase_left;
        m_ready    = 1'b0;
        mode       = 0;
        phase_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_floats.size() == 0) begin
                    $error("result beat with no expectation: bits=%h err=%b",
                           m_float_bits, m_error);
                    fail_count++;
                end else begin
                    want = pending_floats.pop_front();
                    checked_count++;
                    if (m_error) error_beats++;
                    if (m_float_bits !== want.bits) begin
                        $error("float_bits: expected %h, actual %h", want.bits, m_float_bits);
                        fail_count++;
                    end
                    if (m_error !== want.err) begin
                        $error("error: expected %b, actual %b", want.err, m_error);
                        fail_count++;
                    end
                end
            end
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                if (phase_left == 0) begin
                    mode       = $urandom_range(0, 2);
                    phase_left = $urandom_range(20, 200);
                end
                phase_left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog on handshake activity
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results pending", pending_floats.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        decimal_t   d;
        float_res_t none;
        int         burst;
        none.bits          = 32'h0;
        none.err           = 1'b0;
        fail_count         = 0;
        sent_count         = 0;
        checked_count      = 0;
        error_beats        = 0;
        hold_req           = 1'b0;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_coefficient_low  = 64'h0;
        s_coefficient_high = 32'h0;
        s_scale            = 8'h0;
        s_negative         = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows: typed results where obvious, predictor elsewhere
        add_vector(96'd1, 8'd0, 1'b0, 1, 32'h3F80_0000, 1'b0);
        add_vector(96'd10, 8'd1, 1'b1, 1, 32'hBF80_0000, 1'b0);
        add_vector(96'd0, 8'd0, 1'b0, 1, 32'h0000_0000, 1'b0);
        add_vector(96'd0, 8'd28, 1'b1, 1, 32'h8000_0000, 1'b0);
        add_vector(96'd5, 8'd29, 1'b1, 1, 32'h0000_0000, 1'b1);
        add_vector({96{1'b1}}, 8'd255, 1'b0, 1, 32'h0000_0000, 1'b1);
        add_vector(96'd0, 8'd200, 1'b1, 1, 32'h0000_0000, 1'b1);
        add_vector({96{1'b1}}, 8'd0, 1'b0, 0, 32'h0, 1'b0);
        add_vector({96{1'b1}}, 8'd28, 1'b1, 0, 32'h0, 1'b0);
        add_vector(96'd1, 8'd28, 1'b0, 0, 32'h0, 1'b0);
        add_vector(96'd1, 8'd1, 1'b0, 0, 32'h0, 1'b0);
        add_vector(96'd16777217, 8'd0, 1'b0, 0, 32'h0, 1'b0);
        add_vector(96'd16777219, 8'd0, 1'b1, 0, 32'h0, 1'b0);
        add_vector(96'd167772170, 8'd1, 1'b0, 0, 32'h0, 1'b0);
        add_vector(96'hFFFF_FF80_0000_0000_0000_0000, 8'd0, 1'b0, 0, 32'h0, 1'b0);
        add_vector(96'h1_0000_0000_0000_0000, 8'd14, 1'b0, 0, 32'h0, 1'b0);
        add_vector(96'hFFFF_FFFF_FFFF_FFFF, 8'd19, 1'b1, 0, 32'h0, 1'b0);
        add_vector(96'd123456789, 8'd4, 1'b0, 0, 32'h0, 1'b0);
        add_vector(96'd7, 8'd28, 1'b1, 0, 32'h0, 1'b0);
        foreach (vectors[i]) begin
            send_decimal(vectors[i].item, vectors[i].typed, vectors[i].res,
                         1'($urandom_range(0, 1)));
        end
        s_valid <= 1'b0;

        // Let everything drain before the random part
        while (pending_floats.size() != 0) @(posedge aclk);

        burst = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) hold_req = 1'b1;
            if (n == (2 * RANDOM_ITEMS) / 3) begin
                s_valid <= 1'b0;
                while (pending_floats.size() != 0) @(posedge aclk);
            end
            if (burst == 0) burst = $urandom_range(1, 40);
            burst--;
            d = random_decimal();
            send_decimal(d, 1'b0, none, (burst != 0) && (n != RANDOM_ITEMS - 1));
        end
        s_valid <= 1'b0;

        while (pending_floats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("sent %0d scaled decimals, checked %0d results (%0d with scale error)",
                 sent_count, checked_count, error_beats);
        $display("covered signed zeros, scale limits, round-to-even ties and stalls");
        if (fail_count == 0 && pending_floats.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
design/sdsf_pkg.sv
design/sdsf_lz_cell.sv
design/sdsf_div_cell.sv
design/sdsf_round.sv
design/scaled_decimal_to_single_float.sv
test/tb_top.sv
